// File: sv/smah_pkg.sv
`timescale 1ns / 1ps
package smah_pkg;

    localparam int HISTORY_DEPTH = 10;
    localparam int SAMPLE_W      = 24;
    localparam int OUT_W         = 25;
    localparam int WIN_W         = 4;
    localparam int ADDR_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int MAG_W         = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int SUM_W         = MAG_W + 1;
    localparam int STEP_W        = $clog2(MAG_W + 1);
    localparam int IN_TDATA_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((2 * OUT_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef struct packed {
        t_sample right;
        t_sample left;
    } t_pair;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_pair             wr_data;
    } t_mem_req;

    function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
        logic [CNT_W-1:0] n;
        if (w == '0) begin
            n = CNT_W'(1);
        end else if (int'(w) > HISTORY_DEPTH) begin
            n = CNT_W'(HISTORY_DEPTH);
        end else begin
            n = CNT_W'(w);
        end
        return n;
    endfunction

endpackage

// File: sv/stereo_moving_average_highpass_unit.sv
`timescale 1ns / 1ps
// channel   direction  width  contents
// s_axis    in         48     tdata: left_sample[23:0], right_sample[47:24]
// m_axis    out        56     tdata: left_out[24:0], right_out[49:25], zero pad
// cfg       in         4      window_length
//
// A frame passes through these steps before the next frame is accepted: accept, then read,
// shift and sum the history through the memory port (skipped for a window of one), then
// store the new sample, run the 28-step serial divider and load the output register.
// Reset is synchronous, active low; history reads as zero until written.
// A finished result waits in the output register while the next frame is accepted;
// a frame completes only once that register is free.
module stereo_moving_average_highpass_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [smah_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // left_sample, right_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [smah_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // left_out, right_out, pad
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smah_pkg::WIN_W-1:0]          i_cfg_data
);
    import smah_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam int         PAD_W    = OUT_TDATA_W - 2 * OUT_W;

    logic [2:0]        r_state;
    logic [WIN_W-1:0]  r_cfg;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    t_sample           r_l;
    t_sample           r_r;
    t_sum              r_sum_l;
    t_sum              r_sum_r;
    logic              r_out_valid;
    t_out              r_out_l;
    t_out              r_out_r;

    t_mem_req          mem_req;
    t_pair             rd_data;
    logic              rd_issue;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  n_m1;
    logic              div_start;
    t_out              mean_l;
    t_out              mean_r;
    logic              done_l;
    logic              done_r;
    t_sample           in_l;
    t_sample           in_r;

    assign in_l          = s_axis_tdata[SAMPLE_W-1:0];
    assign in_r          = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_r, r_out_l};
    assign div_start     = (r_state == ST_LAST);

    always_comb begin
        idx_m1   = r_idx - 1'b1;
        n_m1     = r_n - 1'b1;
        rd_issue = (r_state == ST_SHIFT) && (r_idx < r_n);
        mem_req  = '0;
        mem_req.rd_en   = rd_issue;
        mem_req.rd_addr = r_idx[ADDR_W-1:0];
        if (r_state == ST_SHIFT && r_pend) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = r_wr_addr;
            mem_req.wr_data = rd_data;
        end else if (r_state == ST_LAST) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = n_m1[ADDR_W-1:0];
            mem_req.wr_data = '{right: r_r, left: r_l};
        end
    end

    smah_hist_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    smah_div u_div_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum_l),
        .i_divisor  (r_n),
        .o_mean     (mean_l),
        .o_done     (done_l)
    );

    smah_div u_div_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum_r),
        .i_divisor  (r_n),
        .o_mean     (mean_r),
        .o_done     (done_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= WIN_W'(1);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_valid && m_axis_tready && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_l     <= in_l;
                        r_r     <= in_r;
                        r_sum_l <= SUM_W'(in_l);
                        r_sum_r <= SUM_W'(in_r);
                        r_n     <= clamp_window(r_cfg);
                        r_idx   <= CNT_W'(1);
                        r_pend  <= 1'b0;
                        r_state <= (clamp_window(r_cfg) == CNT_W'(1)) ? ST_LAST : ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_pend <= rd_issue;
                    if (rd_issue) begin
                        r_idx     <= r_idx + 1'b1;
                        r_wr_addr <= idx_m1[ADDR_W-1:0];
                    end
                    if (r_pend) begin
                        r_sum_l <= r_sum_l + SUM_W'(rd_data.left);
                        r_sum_r <= r_sum_r + SUM_W'(rd_data.right);
                    end
                    if (!rd_issue && !r_pend) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (done_l && done_r) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_l     <= OUT_W'(r_l) - mean_l;
                        r_out_r     <= OUT_W'(r_r) - mean_r;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_idx <= r_n))
        else $error("read index past window");

    a_window_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_n != '0 && r_n <= CNT_W'(HISTORY_DEPTH)))
        else $error("window outside 1..depth");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside final state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_SHIFT || r_state == ST_LAST))
        else $error("accepted frame did not start");
`endif

endmodule

// File: sv/smah_hist_mem.sv
`timescale 1ns / 1ps
module smah_hist_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smah_pkg::t_mem_req i_req,
    output smah_pkg::t_pair   o_rd_data
);
    import smah_pkg::*;

    t_pair r_mem [HISTORY_DEPTH];
    logic  r_valid [HISTORY_DEPTH];
    t_pair r_rd_data;
    logic  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: sv/smah_div.sv
`timescale 1ns / 1ps
module smah_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  smah_pkg::t_sum              i_dividend,
    input  logic [smah_pkg::CNT_W-1:0]  i_divisor,
    output smah_pkg::t_out              o_mean,
    output logic                        o_done
);
    import smah_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [MAG_W-1:0]  r_q;
    logic              r_neg;

    t_sum              abs_div;
    logic [CNT_W:0]    trial;
    logic              ge;
    logic [CNT_W:0]    diff;
    t_out              mag;

    always_comb begin
        abs_div = i_dividend[SUM_W-1] ? -i_dividend : i_dividend;
        trial   = {r_rem, r_q[MAG_W-1]};
        ge      = trial >= {1'b0, r_div};
        diff    = trial - {1'b0, r_div};
        mag     = {1'b0, r_q[OUT_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= abs_div[MAG_W-1:0];
            r_neg <= i_dividend[SUM_W-1];
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[MAG_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(MAG_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_mean = r_neg ? -mag : mag;
    assign o_done = r_done;

endmodule
